// ===== hdl/cft_pkg.sv =====
// Shared types for the completion frontier tracker.
// No dependencies; imported by the sequencer, the done cells and the top level.
package cft_pkg;

   // Control handed from the sequencer to every done cell
   typedef struct packed {
      logic clear;   // drop every done bit (total_units written)
      logic shift;   // frontier advances: take the upper neighbor's bit
      logic mark;    // set the bit of the cell whose offset matches
   } cft_ctl_type;

endpackage

// ===== hdl/cft_cell.sv =====
// One done cell of the window: holds the done bit for one offset above the frontier.
// Depends on cft_pkg for the control struct.
module cft_cell
   import cft_pkg::*;
#(
   parameter int IDX_W   = 6,
   parameter int CELL_ID = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  cft_ctl_type      ctl,
   input  logic [IDX_W-1:0] offset,
   input  logic             upper_done,
   output logic             done
);

   logic done_ff;
   logic done_in;

   // Clear wins; shift pulls from the upper neighbor; mark sets on offset match; else hold
   always_comb begin
      done_in = done_ff;
      priority if (ctl.clear) begin
         done_in = 1'b0;
      end else if (ctl.shift) begin
         done_in = upper_done;
      end else if (ctl.mark && (offset == IDX_W'(CELL_ID))) begin
         done_in = 1'b1;
      end else begin
         done_in = done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   assign done = done_ff;

endmodule

// ===== hdl/cft_seq.sv =====
// Sequencer of the completion frontier tracker: range checks, frontier, total,
// advance walk and the result register. Depends on cft_pkg.
module cft_seq
   import cft_pkg::*;
#(
   parameter int WINDOW_SIZE = 64,
   parameter int IDX_W       = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [31:0]      req_unit_index,
   input  logic             csr_we,
   input  logic [31:0]      csr_wdata,
   input  logic             next_done,
   output cft_ctl_type      ctl,
   output logic [IDX_W-1:0] offset,
   output logic             rsp_valid,
   output logic             rsp_advanced,
   output logic [31:0]      rsp_frontier,
   output logic             rsp_ignored,
   output logic             rsp_overflow
);

   localparam int STEP_W = $clog2(WINDOW_SIZE + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_ADV  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [31:0]       index_ff, index_in;
   logic [31:0]       frontier_ff, frontier_in;
   logic [31:0]       total_ff, total_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_advanced_ff, rsp_advanced_in;
   logic              rsp_ignored_ff, rsp_ignored_in;
   logic              rsp_overflow_ff, rsp_overflow_in;

   logic [31:0]       offset_full;
   logic              is_ignored;
   logic              is_far;
   logic              is_head;
   logic [STEP_W-1:0] steps_inc;

   // Classify the pending index against the frontier and the job size
   assign offset_full = index_ff - frontier_ff;
   assign is_ignored  = (index_ff < frontier_ff) || (index_ff >= total_ff);
   assign is_far      = offset_full >= 32'(WINDOW_SIZE);
   assign is_head     = offset_full == 32'd0;
   assign steps_inc   = steps_ff + STEP_W'(1);

   always_comb begin
      state_in        = state_ff;
      index_in        = index_ff;
      frontier_in     = frontier_ff;
      total_in        = total_ff;
      steps_in        = steps_ff;
      rsp_valid_in    = 1'b0;
      rsp_advanced_in = rsp_advanced_ff;
      rsp_ignored_in  = rsp_ignored_ff;
      rsp_overflow_in = rsp_overflow_ff;
      ctl.clear       = csr_we;
      ctl.shift       = 1'b0;
      ctl.mark        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // Take a new transfer
            if (start) begin
               index_in = req_unit_index;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            rsp_advanced_in = 1'b0;
            rsp_ignored_in  = 1'b0;
            rsp_overflow_in = 1'b0;
            priority if (is_ignored) begin
               rsp_ignored_in = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end else if (is_far) begin
               rsp_overflow_in = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end else if (is_head) begin
               // Retire the frontier slot; keep walking while the next is done
               ctl.shift       = 1'b1;
               frontier_in     = frontier_ff + 32'd1;
               steps_in        = STEP_W'(1);
               rsp_advanced_in = 1'b1;
               if (next_done) begin
                  state_in = ST_ADV;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               ctl.mark     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_ADV: begin
            // Advance one slot per cycle until a gap or a full window
            ctl.shift   = 1'b1;
            frontier_in = frontier_ff + 32'd1;
            steps_in    = steps_inc;
            if (!(next_done && (steps_inc < STEP_W'(WINDOW_SIZE)))) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A total write restarts the job
      if (csr_we) begin
         total_in    = csr_wdata;
         frontier_in = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frontier_ff  <= 32'd0;
         total_ff     <= 32'd0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frontier_ff  <= frontier_in;
         total_ff     <= total_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      index_ff        <= index_in;
      rsp_advanced_ff <= rsp_advanced_in;
      rsp_ignored_ff  <= rsp_ignored_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign busy         = state_ff != ST_IDLE;
   assign offset       = offset_full[IDX_W-1:0];
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_advanced = rsp_advanced_ff;
   assign rsp_frontier = frontier_ff;
   assign rsp_ignored  = rsp_ignored_ff;
   assign rsp_overflow = rsp_overflow_ff;

`ifndef SYNTHESIS
   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_advanced_ff, rsp_ignored_ff, rsp_overflow_ff}))
      else $error("more than one result flag set");

   a_frontier_bound: assert property (@(posedge clock) disable iff (reset)
      frontier_ff <= total_ff)
      else $error("frontier passed total_units");

   a_shift_xor_mark: assert property (@(posedge clock) disable iff (reset)
      !(ctl.shift && ctl.mark))
      else $error("shift and mark in the same cycle");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADV) |-> (steps_ff < STEP_W'(WINDOW_SIZE)))
      else $error("advance walk exceeded the window");

   a_adv_moves: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADV) |=> (frontier_ff == $past(frontier_ff) + 32'd1))
      else $error("frontier did not move during advance");
`endif

endmodule

// ===== hdl/completion_frontier_tracker.sv =====
// Top level of the completion frontier tracker: sequencer plus a chain of done cells.
// Depends on cft_pkg, cft_seq and cft_cell.
//
// Reports finished work-unit indices in any order and tracks the in-order frontier,
// the lowest index not yet finished. An item is taken when start is high and busy is
// low; exactly one result follows, shown for one cycle with rsp_valid, and it cannot
// be held off. No new item is taken before the result of the last one is shown. An
// item equal to the frontier also walks the frontier past the already finished units
// directly above it (at most WINDOW_SIZE - 1): the done bits sit in a chain of
// WINDOW_SIZE cells that shifts by one slot per cycle as the frontier advances.
// Indices below total_units but at or beyond frontier + WINDOW_SIZE are flagged with
// overflow and dropped. Writing csr_wdata with csr_we sets total_units, clears all
// done bits and returns the frontier to zero; write it only while the block is idle.
module completion_frontier_tracker
   import cft_pkg::*;
#(
   parameter int WINDOW_SIZE = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_unit_index,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   output logic        rsp_valid,
   output logic        rsp_advanced,
   output logic [31:0] rsp_frontier,
   output logic        rsp_ignored,
   output logic        rsp_overflow
);

   localparam int IDX_W = $clog2(WINDOW_SIZE);

   cft_ctl_type      ctl;
   logic [IDX_W-1:0] offset;
   logic             done_vec [WINDOW_SIZE];

   // Sequencer: checks, frontier and result
   cft_seq #(
      .WINDOW_SIZE (WINDOW_SIZE),
      .IDX_W       (IDX_W)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_unit_index (req_unit_index),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .next_done      (done_vec[1]),
      .ctl            (ctl),
      .offset         (offset),
      .rsp_valid      (rsp_valid),
      .rsp_advanced   (rsp_advanced),
      .rsp_frontier   (rsp_frontier),
      .rsp_ignored    (rsp_ignored),
      .rsp_overflow   (rsp_overflow)
   );

   // Chain of done cells; cell k holds offset k above the frontier
   for (genvar k = 0; k < WINDOW_SIZE; k++) begin : g_cell
      logic upper;
      if (k == WINDOW_SIZE - 1) begin : g_top
         assign upper = 1'b0;
      end else begin : g_mid
         assign upper = done_vec[k+1];
      end

      cft_cell #(
         .IDX_W   (IDX_W),
         .CELL_ID (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .offset     (offset),
         .upper_done (upper),
         .done       (done_vec[k])
      );
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the completion frontier tracker.
// Needs only completion_frontier_tracker and its submodules; predicts every result in place.
module testbench;

   localparam int WINDOW = 64;
   localparam int OFS_W  = $clog2(WINDOW);

   typedef struct packed {
      logic        advanced;
      logic [31:0] frontier;
      logic        ignored;
      logic        overflow;
   } frontier_status_type;

   typedef struct {
      bit          is_cfg;
      logic [31:0] value;
   } work_op_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_unit_index;
   logic        csr_we;
   logic [31:0] csr_wdata;
   logic        rsp_valid;
   logic        rsp_advanced;
   logic [31:0] rsp_frontier;
   logic        rsp_ignored;
   logic        rsp_overflow;

   // Predictor state: frontier plus done bits, bit k standing for unit frontier + k
   logic [31:0]       mdl_total;
   logic [31:0]       mdl_frontier;
   logic [WINDOW-1:0] mdl_done;

   work_op_type         unit_feed_q[$];
   frontier_status_type status_due_q[$];

   bit req_taken;
   int burst_left;
   int gap_left;
   int fail_count;
   int units_sent;
   int status_seen;
   int total_writes;
   int advance_count;
   int ignore_count;
   int overflow_count;

   completion_frontier_tracker #(
      .WINDOW_SIZE(WINDOW)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_unit_index (req_unit_index),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_advanced   (rsp_advanced),
      .rsp_frontier   (rsp_frontier),
      .rsp_ignored    (rsp_ignored),
      .rsp_overflow   (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Retire one finished unit and return the status the block should report
   function automatic frontier_status_type retire_unit(logic [31:0] idx);
      frontier_status_type st;
      logic [31:0]         offset;
      int                  steps;
      st = '0;
      if (idx < mdl_frontier || idx >= mdl_total) begin
         st.ignored = 1'b1;
      end else begin
         offset = idx - mdl_frontier;
         if (offset >= WINDOW) begin
            st.overflow = 1'b1;
         end else if (offset == 0) begin
            // step past the frontier, then past every contiguous done unit
            st.advanced = 1'b1;
            mdl_done = mdl_done >> 1;
            mdl_frontier = mdl_frontier + 32'd1;
            steps = 1;
            while (steps < WINDOW && mdl_done[0]) begin
               mdl_done = mdl_done >> 1;
               mdl_frontier = mdl_frontier + 32'd1;
               steps++;
            end
         end else begin
            mdl_done[offset[OFS_W-1:0]] = 1'b1;
         end
      end
      st.frontier = mdl_frontier;
      return st;
   endfunction

   task automatic note_failure(string what);
      fail_count++;
      if (fail_count <= 10) $display("%s", what);
   endtask

   task automatic add_item(logic [31:0] v);
      work_op_type op;
      op.is_cfg = 1'b0;
      op.value = v;
      unit_feed_q.push_back(op);
   endtask

   task automatic add_cfg(logic [31:0] v);
      work_op_type op;
      op.is_cfg = 1'b1;
      op.value = v;
      unit_feed_q.push_back(op);
   endtask

   // Off-sequence index: random, behind, past the window, past the job, or inside the window
   task automatic add_noise(longint base, logic [31:0] total);
      case ($urandom_range(0, 4))
         0: add_item($urandom);
         1: add_item(base > 0 ? $urandom_range(0, int'(base - 1)) : $urandom);
         2: add_item(32'(base + WINDOW + $urandom_range(0, 200)));
         3: add_item(total + $urandom_range(0, 50));
         default: add_item(32'(base + $urandom_range(0, WINDOW - 1)));
      endcase
   endtask

   // One job: set the total, then finish units in shuffled blocks that fit the window
   task automatic add_job(logic [31:0] total, int count);
      longint      tot;
      longint      base;
      int          emitted;
      int          len;
      int          k;
      logic [31:0] blk[WINDOW];
      logic [31:0] tmp;
      tot = total;
      base = 0;
      emitted = 0;
      add_cfg(total);
      while (emitted < count) begin
         if (base >= tot) begin
            add_noise(base, total);
            emitted++;
         end else begin
            len = $urandom_range(1, WINDOW);
            if (base + len > tot) len = int'(tot - base);
            for (int j = 0; j < len; j++) blk[j] = 32'(base + j);
            for (int j = len - 1; j > 0; j--) begin
               k = $urandom_range(0, j);
               tmp = blk[j];
               blk[j] = blk[k];
               blk[k] = tmp;
            end
            for (int j = 0; j < len && emitted < count; j++) begin
               if ($urandom_range(0, 7) == 0) begin
                  add_noise(base, total);
                  emitted++;
               end
               add_item(blk[j]);
               emitted++;
            end
            base += len;
         end
      end
   endtask

   // Monitor: check results, track register writes, predict each accepted transfer
   always @(posedge clock) begin
      frontier_status_type due;
      req_taken = 1'b0;
      if (reset) begin
         mdl_total = '0;
         mdl_frontier = '0;
         mdl_done = '0;
         status_due_q.delete();
      end else begin
         if (rsp_valid) begin
            status_seen++;
            if (status_due_q.size() == 0) begin
               note_failure($sformatf("unexpected result: frontier=%0d", rsp_frontier));
            end else begin
               due = status_due_q.pop_front();
               if (rsp_advanced !== due.advanced || rsp_frontier !== due.frontier ||
                   rsp_ignored !== due.ignored || rsp_overflow !== due.overflow) begin
                  note_failure($sformatf({"result mismatch: expected adv=%0b frontier=%0d",
                     " ign=%0b ovf=%0b, got adv=%0b frontier=%0d ign=%0b ovf=%0b"},
                     due.advanced, due.frontier, due.ignored, due.overflow,
                     rsp_advanced, rsp_frontier, rsp_ignored, rsp_overflow));
               end
            end
         end
         if (csr_we) begin
            mdl_total = csr_wdata;
            mdl_frontier = '0;
            mdl_done = '0;
            total_writes++;
         end
         if (start && !busy) begin
            req_taken = 1'b1;
            due = retire_unit(req_unit_index);
            advance_count += due.advanced;
            ignore_count += due.ignored;
            overflow_count += due.overflow;
            status_due_q.push_back(due);
            units_sent++;
         end
      end
   end

   // Driver: issue transfers in bursts, write the total only once the block is drained
   always @(negedge clock) begin
      logic        nxt_start;
      logic [31:0] nxt_index;
      logic        nxt_we;
      logic [31:0] nxt_wdata;
      work_op_type op;
      nxt_start = start;
      nxt_index = req_unit_index;
      nxt_we = 1'b0;
      nxt_wdata = csr_wdata;
      if (!reset) begin
         if (start && req_taken) nxt_start = 1'b0;
         if (!nxt_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (unit_feed_q.size() > 0) begin
               op = unit_feed_q[0];
               if (op.is_cfg) begin
                  if (status_due_q.size() == 0 && !busy && !start) begin
                     nxt_we = 1'b1;
                     nxt_wdata = op.value;
                     void'(unit_feed_q.pop_front());
                  end
               end else begin
                  nxt_start = 1'b1;
                  nxt_index = op.value;
                  void'(unit_feed_q.pop_front());
                  if (burst_left <= 1) begin
                     burst_left = $urandom_range(1, 40);
                     case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left = 0;
                        4, 5, 6, 7: gap_left = $urandom_range(1, 4);
                        8: gap_left = $urandom_range(5, 12);
                        default: gap_left = $urandom_range(20, 40);
                     endcase
                  end else begin
                     burst_left--;
                  end
               end
            end
         end
      end
      start <= nxt_start;
      req_unit_index <= nxt_index;
      csr_we <= nxt_we;
      csr_wdata <= nxt_wdata;
   end

   // Hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int drain_cycles;
      reset = 1'b1;
      start = 1'b0;
      req_unit_index = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_taken = 1'b0;
      burst_left = 0;
      gap_left = 0;
      fail_count = 0;
      units_sent = 0;
      status_seen = 0;
      total_writes = 0;
      advance_count = 0;
      ignore_count = 0;
      overflow_count = 0;

      // Empty job right after reset: everything is past the job
      add_item(32'h0000_0000);
      add_item(32'hFFFF_FFFF);
      // Tiny job: mark, repeat, advance to completion, then past and behind
      add_cfg(32'd3);
      add_item(32'd2);
      add_item(32'd1);
      add_item(32'd1);
      add_item(32'd0);
      add_item(32'd3);
      add_item(32'd0);
      // Largest job: window edge, top index, and alternating bit patterns
      add_cfg(32'hFFFF_FFFF);
      add_item(32'd64);
      add_item(32'hFFFF_FFFF);
      add_item(32'd63);
      add_item(32'd0);
      add_item(32'd64);
      add_item(32'd65);
      add_item(32'hAAAA_AAAA);
      add_item(32'h5555_5555);
      add_item(32'hFFFF_FFFE);

      // Random jobs over a spread of totals
      add_job(32'hFFFF_FFFF, 150);
      add_job(32'd1, 20);
      add_job(32'd200, 160);
      add_job($urandom_range(2, 6), 30);
      add_job(32'd64, 90);
      add_job(32'd65, 90);
      add_job($urandom_range(300, 1000), 200);
      add_job(32'd0, 15);
      add_job(32'd130, 100);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain: all transfers out, all results back, then let the block settle
      while (unit_feed_q.size() > 0 || start) @(posedge clock);
      drain_cycles = 0;
      while (status_due_q.size() > 0 && drain_cycles < 10000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (WINDOW + 8) @(posedge clock);
      if (status_due_q.size() > 0)
         note_failure($sformatf("%0d results never arrived", status_due_q.size()));

      $display("Run covered %0d transfers and %0d results over %0d total_units writes",
               units_sent, status_seen, total_writes);
      $display("Outcomes: %0d advances, %0d ignored, %0d overflow; %0d failures",
               advance_count, ignore_count, overflow_count, fail_count);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
